// ===== sv/rotate_point_about_center_core_assert.svh =====
// Assertion macros for the rotate-point top level.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ROTATE_POINT_ABOUT_CENTER_CORE_ASSERT_SVH
`define ROTATE_POINT_ABOUT_CENTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rpc_pkg.sv =====
// Shared types, widths and constants for the rotate-point-about-center core.
// Holds the CORDIC angle table function used by every rotation cell.
// No dependencies.
package rpc_pkg;

  // Field and datapath widths.
  localparam int DW   = 32;   // Q16.16 coordinate
  localparam int AW   = 16;   // binary angle
  localparam int RW   = 14;   // residual angle inside one quadrant
  localparam int XW   = 33;   // CORDIC x/y, Q30 with headroom
  localparam int ZW   = 51;   // CORDIC residual angle, Q48 radians
  localparam int UW   = 35;   // angle unit width
  localparam int PW   = 2 * XW;

  // Stage count limits.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 32;

  // pi in Q60, the angle unit floor(pi * 2^33) and the CORDIC gain in Q30.
  localparam logic [63:0]   PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [UW-1:0] ANG_UNIT = UW'(PI_Q60 >> 27);
  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

  // Quadrant codes after the angle is folded.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } rpc_quad_t;

  // Rotation vector carried from cell to cell.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rpc_vec_t;

  // Sideband that rides along the CORDIC chain.
  typedef struct packed {
    rpc_quad_t            quad;
    logic signed [DW:0]   dx;
    logic signed [DW:0]   dy;
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
  } rpc_side_t;

  // Arctangent of 2^-idx in Q48, built from a Taylor series in Q62 and
  // rounded to nearest in Q48. Index zero holds atan(1), an eighth turn of pi/4.
  // Evaluated at elaboration only.
  function automatic logic [ZW-1:0] atan_q48(input int unsigned idx);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned e;
    int unsigned k;
    pos = 64'd0;
    neg = 64'd0;
    if (idx == 0) begin
      acc = PI_Q60;
    end else begin
      for (k = 0; k < 32; k++) begin
        e = idx * (2 * k + 1);
        if (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          if (k[0]) begin
            neg = neg + term;
          end else begin
            pos = pos + term;
          end
        end
      end
      acc = pos - neg;
    end
    return ZW'((acc + 64'd8192) >> 14);
  endfunction

endpackage

// ===== sv/rpc_prep.sv =====
// Entry stage: folds the binary angle into a quadrant and a residual angle,
// and forms the point-minus-center differences. Depends on rpc_pkg.
module rpc_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          i_valid,
  output logic                          i_ready,
  input  logic signed [rpc_pkg::DW-1:0] point_x,
  input  logic signed [rpc_pkg::DW-1:0] point_y,
  input  logic signed [rpc_pkg::DW-1:0] center_x,
  input  logic signed [rpc_pkg::DW-1:0] center_y,
  input  logic        [rpc_pkg::AW-1:0] turn_angle,
  output logic                          o_valid,
  input  logic                          o_ready,
  output rpc_pkg::rpc_vec_t             o_vec,
  output rpc_pkg::rpc_side_t            o_side
);

  localparam int AW = rpc_pkg::AW;
  localparam int RW = rpc_pkg::RW;
  localparam int ZW = rpc_pkg::ZW;
  localparam int UW = rpc_pkg::UW;

  logic [AW-1:0]              ang_shift;
  logic signed [RW-1:0]       resid;
  logic signed [RW+UW:0]      z_prod;
  logic                       vld_r;
  rpc_pkg::rpc_vec_t          vec_r;
  rpc_pkg::rpc_vec_t          vec_nxt;
  rpc_pkg::rpc_side_t         side_r;
  rpc_pkg::rpc_side_t         side_nxt;

  // Shift by an eighth turn so each quadrant is centered on its axis; the
  // residual is the low bits with the top bit flipped, i.e. minus 0x2000.
  always_comb begin
    ang_shift = turn_angle + AW'(16'h2000);
    resid     = {~ang_shift[RW-1], ang_shift[RW-2:0]};
    z_prod    = resid * $signed({1'b0, rpc_pkg::ANG_UNIT});
  end

  // Starting vector and sideband for the CORDIC chain.
  always_comb begin
    vec_nxt.x     = rpc_pkg::GAIN_Q30;
    vec_nxt.y     = '0;
    vec_nxt.z     = ZW'(z_prod);
    side_nxt.quad = rpc_pkg::rpc_quad_t'(ang_shift[AW-1:AW-2]);
    side_nxt.dx   = {point_x[31], point_x} - {center_x[31], center_x};
    side_nxt.dy   = {point_y[31], point_y} - {center_y[31], center_y};
    side_nxt.cx   = center_x;
    side_nxt.cy   = center_y;
  end

  assign i_ready = !vld_r || o_ready;

  // Stage register: loads whenever the stage is empty or drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_ready) begin
      vld_r <= i_valid;
    end
    if (i_valid && i_ready) begin
      vec_r  <= vec_nxt;
      side_r <= side_nxt;
    end
  end

  assign o_valid = vld_r;
  assign o_vec   = vec_r;
  assign o_side  = side_r;

endmodule

// ===== sv/rpc_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation by atan(2^-IDX).
// Depends on rpc_pkg for the vector types and the angle table.
module rpc_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               i_valid,
  output logic               i_ready,
  input  rpc_pkg::rpc_vec_t  i_vec,
  input  rpc_pkg::rpc_side_t i_side,
  output logic               o_valid,
  input  logic               o_ready,
  output rpc_pkg::rpc_vec_t  o_vec,
  output rpc_pkg::rpc_side_t o_side
);

  localparam int XW = rpc_pkg::XW;
  localparam int ZW = rpc_pkg::ZW;
  localparam logic signed [ZW-1:0] ANG = rpc_pkg::atan_q48(IDX);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 vld_r;
  rpc_pkg::rpc_vec_t    vec_r;
  rpc_pkg::rpc_vec_t    vec_nxt;
  rpc_pkg::rpc_side_t   side_r;

  // Rotate toward zero residual angle; both updates use the old x and y.
  always_comb begin
    xs = $signed(i_vec.x) >>> IDX;
    ys = $signed(i_vec.y) >>> IDX;
    if (!i_vec.z[ZW-1]) begin
      vec_nxt.x = i_vec.x - ys;
      vec_nxt.y = i_vec.y + xs;
      vec_nxt.z = i_vec.z - ANG;
    end else begin
      vec_nxt.x = i_vec.x + ys;
      vec_nxt.y = i_vec.y - xs;
      vec_nxt.z = i_vec.z + ANG;
    end
  end

  assign i_ready = !vld_r || o_ready;

  // Cell register with its own valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_ready) begin
      vld_r <= i_valid;
    end
    if (i_valid && i_ready) begin
      vec_r  <= vec_nxt;
      side_r <= i_side;
    end
  end

  assign o_valid = vld_r;
  assign o_vec   = vec_r;
  assign o_side  = side_r;

endmodule

// ===== sv/rpc_post.sv =====
// Back end: maps the CORDIC result to cosine and sine by quadrant, rotates
// the offset, rounds, adds the center back and saturates. Depends on rpc_pkg.
module rpc_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          i_valid,
  output logic                          i_ready,
  input  rpc_pkg::rpc_vec_t             i_vec,
  input  rpc_pkg::rpc_side_t            i_side,
  output logic                          o_valid,
  input  logic                          o_ready,
  output logic signed [rpc_pkg::DW-1:0] o_rotated_x,
  output logic signed [rpc_pkg::DW-1:0] o_rotated_y,
  output logic                          o_saturated
);

  localparam int DW = rpc_pkg::DW;
  localparam int XW = rpc_pkg::XW;
  localparam int PW = rpc_pkg::PW;
  localparam int SW = PW + 1;        // product sum
  localparam int QW = SW - 30;       // rounded Q16.16 offset
  localparam int VW = QW + 1;        // offset plus center

  logic signed [XW-1:0] cs;
  logic signed [XW-1:0] sn;

  // Stage 1: the four products.
  logic                 v1_r;
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [DW-1:0] cx1_r, cy1_r;
  // Stage 2: rounded rotated offsets.
  logic                 v2_r;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [QW-1:0] rnd_x_nxt, rnd_y_nxt;
  logic signed [QW-1:0] rnd_x_r, rnd_y_r;
  logic signed [DW-1:0] cx2_r, cy2_r;
  // Stage 3: output register.
  logic                 v3_r;
  logic signed [VW-1:0] full_x, full_y;
  logic signed [DW-1:0] rx_nxt, ry_nxt;
  logic                 sat_x, sat_y;
  logic signed [DW-1:0] rx_r, ry_r;
  logic                 sat_r;
  logic                 rdy1, rdy2, rdy3;

  // Elastic ready chain through the three stages.
  assign rdy3    = !v3_r || o_ready;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign i_ready = rdy1;

  // Quadrant map of the CORDIC vector to cosine and sine.
  always_comb begin
    case (i_side.quad)
      rpc_pkg::QUAD_0: begin
        cs = i_vec.x;
        sn = i_vec.y;
      end
      rpc_pkg::QUAD_1: begin
        cs = -i_vec.y;
        sn = i_vec.x;
      end
      rpc_pkg::QUAD_2: begin
        cs = -i_vec.x;
        sn = -i_vec.y;
      end
      rpc_pkg::QUAD_3: begin
        cs = i_vec.y;
        sn = -i_vec.x;
      end
      default: begin
        cs = i_vec.x;
        sn = i_vec.y;
      end
    endcase
  end

  // Round half up at bit 30 with a floor shift, taken as a part-select.
  always_comb begin
    sum_x = SW'(p_xc_r) - SW'(p_ys_r) + SW'(64'd1 << 29);
    sum_y = SW'(p_xs_r) + SW'(p_yc_r) + SW'(64'd1 << 29);
    rnd_x_nxt = sum_x[SW-1:30];
    rnd_y_nxt = sum_y[SW-1:30];
  end

  // Add the center back and clip to the signed 32-bit range.
  always_comb begin
    full_x = VW'(rnd_x_r) + VW'(cx2_r);
    full_y = VW'(rnd_y_r) + VW'(cy2_r);
    sat_x  = (full_x[VW-1:DW-1] != {(VW-DW+1){full_x[VW-1]}});
    sat_y  = (full_y[VW-1:DW-1] != {(VW-DW+1){full_y[VW-1]}});
    if (sat_x) begin
      rx_nxt = full_x[VW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      rx_nxt = full_x[DW-1:0];
    end
    if (sat_y) begin
      ry_nxt = full_y[VW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      ry_nxt = full_y[DW-1:0];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= i_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload registers; each loads on a transfer into its stage.
  always_ff @(posedge clk) begin
    if (i_valid && rdy1) begin
      p_xc_r <= i_side.dx * cs;
      p_ys_r <= i_side.dy * sn;
      p_xs_r <= i_side.dx * sn;
      p_yc_r <= i_side.dy * cs;
      cx1_r  <= i_side.cx;
      cy1_r  <= i_side.cy;
    end
    if (v1_r && rdy2) begin
      rnd_x_r <= rnd_x_nxt;
      rnd_y_r <= rnd_y_nxt;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
    end
    if (v2_r && rdy3) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      sat_r <= sat_x || sat_y;
    end
  end

  assign o_valid     = v3_r;
  assign o_rotated_x = rx_r;
  assign o_rotated_y = ry_r;
  assign o_saturated = sat_r;

endmodule

// ===== sv/rotate_point_about_center_core.sv =====
// Top level of the rotate-point-about-center core.
// Depends on rpc_pkg, rpc_prep, rpc_cell, rpc_post and the assertion header.
//
// Usage:
//   Input channel in_*: a point, a center (signed Q16.16) and a 16-bit binary
//   angle, 65536 per turn, counter-clockwise. Output channel out_*: the
//   rotated point, saturated to the signed 32-bit range, and a flag that is
//   set when either coordinate was clipped. Both channels transfer on
//   valid && ready.
//   The pipeline has one entry stage, one register per CORDIC cell and three
//   back-end stages (products, rounding, center add and clip into the output
//   register). Throughput is one point per cycle while out_ready stays high,
//   set by the chain of CORDIC cells, each holding one item.
//   Every stage has its own valid bit and loads when it is empty or drains,
//   so while the receiver stalls, empty stages upstream keep filling and
//   in_ready drops only once every stage holds an item.
//   Reset clears all valid bits; the pipeline is empty afterwards and needs
//   no warm-up.
module rotate_point_about_center_core #(
  parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [rpc_pkg::DW-1:0] in_point_x,
  input  logic signed [rpc_pkg::DW-1:0] in_point_y,
  input  logic signed [rpc_pkg::DW-1:0] in_center_x,
  input  logic signed [rpc_pkg::DW-1:0] in_center_y,
  input  logic        [rpc_pkg::AW-1:0] in_turn_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [rpc_pkg::DW-1:0] out_rotated_x,
  output logic signed [rpc_pkg::DW-1:0] out_rotated_y,
  output logic                          out_saturated
);

`include "rotate_point_about_center_core_assert.svh"

  localparam int NSTG = (CORDIC_STAGES > rpc_pkg::MAX_STAGES) ?
                        rpc_pkg::MAX_STAGES : CORDIC_STAGES;

  // Link k feeds cell k; link NSTG feeds the back end.
  logic               chain_vld [NSTG+1];
  logic               chain_rdy [NSTG+1];
  rpc_pkg::rpc_vec_t  chain_vec [NSTG+1];
  rpc_pkg::rpc_side_t chain_side[NSTG+1];
  logic [NSTG-1:0]    cell_full;

  // Entry stage.
  rpc_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .i_valid    (in_valid),
    .i_ready    (in_ready),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .center_x   (in_center_x),
    .center_y   (in_center_y),
    .turn_angle (in_turn_angle),
    .o_valid    (chain_vld[0]),
    .o_ready    (chain_rdy[0]),
    .o_vec      (chain_vec[0]),
    .o_side     (chain_side[0])
  );

  // Row of CORDIC cells.
  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    rpc_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (chain_vld[g]),
      .i_ready (chain_rdy[g]),
      .i_vec   (chain_vec[g]),
      .i_side  (chain_side[g]),
      .o_valid (chain_vld[g+1]),
      .o_ready (chain_rdy[g+1]),
      .o_vec   (chain_vec[g+1]),
      .o_side  (chain_side[g+1])
    );
    assign cell_full[g] = chain_vld[g+1];
  end

  // Rotation, rounding and saturation.
  rpc_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .i_valid     (chain_vld[NSTG]),
    .i_ready     (chain_rdy[NSTG]),
    .i_vec       (chain_vec[NSTG]),
    .i_side      (chain_side[NSTG]),
    .o_valid     (out_valid),
    .o_ready     (out_ready),
    .o_rotated_x (out_rotated_x),
    .o_rotated_y (out_rotated_y),
    .o_saturated (out_saturated)
  );

  // An empty output register makes every stage upstream ready.
  `RPC_ASSERT_IMPLY(a_empty_out_ready, !out_valid, in_ready,
    "input not ready while the output register is empty")

  // An accepted item occupies the entry stage on the next cycle.
  `RPC_ASSERT_NEXT(a_accept_fills_entry, in_valid && in_ready, chain_vld[0],
    "accepted item did not reach the entry stage")

  // A full chain in front of a stalled back end must refuse input.
  `RPC_ASSERT_IMPLY(a_full_chain_stalls,
    chain_vld[0] && (&cell_full) && !chain_rdy[NSTG], !in_ready,
    "input accepted while the whole chain is full and stalled")

endmodule

// ===== sim/rotate_point_about_center_core_tb.sv =====
// Self-checking testbench for rotate_point_about_center_core.
// Depends on rpc_pkg and the core; predicts each rotated point from a
// CORDIC model of its own and checks it under random gaps and stalls.
`timescale 1ns / 100ps

module rotate_point_about_center_core_tb;

  localparam int STAGES       = 16;
  localparam int LOOP_STAGES  = (STAGES > 32) ? 32 : STAGES;
  localparam int LATENCY      = STAGES + 4;
  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 160;
  localparam int MAX_REPORTS  = 10;

  localparam logic [63:0] PI_Q60_C = 64'h3243F6A8885A308D;
  localparam longint      ANG_STEP = longint'(PI_Q60_C >> 27);
  localparam longint      K_GAIN   = 64'sd652032874;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_COIN   = 2'd1,
    RX_SPARSE = 2'd2,
    RX_BEAT   = 2'd3
  } rx_mode_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [15:0] ang;
  } point_job_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               sat;
  } rotated_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   in_point_x    = '0;
  logic signed [31:0]   in_point_y    = '0;
  logic signed [31:0]   in_center_x   = '0;
  logic signed [31:0]   in_center_y   = '0;
  logic        [15:0]   in_turn_angle = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic signed [31:0]   out_rotated_x;
  logic signed [31:0]   out_rotated_y;
  logic                 out_saturated;

  point_job_t point_q[$];
  rotated_t   rotated_q[$];
  point_job_t cur_job;
  rotated_t   want;

  int tx_burst_left = 1;
  int tx_gap_left   = 0;
  int n_sent        = 0;
  int n_recv        = 0;
  int n_clip        = 0;
  int n_fail        = 0;
  int n_stall       = 0;
  int idle_cycles   = 0;

  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  bit       rx_held      = 1'b0;
  int       rx_beat      = 0;
  logic     rx_rdy;

  rotate_point_about_center_core #(
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_turn_angle (in_turn_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rotated_x (out_rotated_x),
    .out_rotated_y (out_rotated_y),
    .out_saturated (out_saturated)
  );

  // Arctangent of 2^-idx in Q48 from an alternating Taylor series in Q62.
  function automatic longint arctan_q48(input int unsigned idx);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned n;
    int unsigned e;
    sum = 64'd0;
    n   = 1;
    e   = idx;
    if (idx == 0) begin
      sum = PI_Q60_C;
    end else begin
      while (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(n);
        if (n[1]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        n = n + 2;
        e = idx * n;
      end
    end
    return longint'((sum + 64'd8192) >> 14);
  endfunction

  // Expected rotated point: fold the angle, run the CORDIC, rotate, round,
  // add the center back and clip each coordinate.
  function automatic rotated_t rotate_about(input point_job_t j);
    logic [16:0]        a;
    rpc_pkg::rpc_quad_t q;
    longint             r;
    longint             x;
    longint             y;
    longint             z;
    longint             xs;
    longint             ys;
    longint             cs;
    longint             sn;
    logic signed [79:0] dx;
    logic signed [79:0] dy;
    logic signed [79:0] vx;
    logic signed [79:0] vy;
    rotated_t           res;
    a = {1'b0, j.ang} + 17'h2000;
    q = rpc_pkg::rpc_quad_t'(a[15:14]);
    r = longint'({50'd0, a[13:0]}) - 64'sd8192;
    z = r * ANG_STEP;
    x = K_GAIN;
    y = 0;
    for (int i = 0; i < LOOP_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q48(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q48(i);
      end
    end
    case (q)
      rpc_pkg::QUAD_0: begin cs = x;  sn = y;  end
      rpc_pkg::QUAD_1: begin cs = -y; sn = x;  end
      rpc_pkg::QUAD_2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    dx = j.px;
    dx = dx - j.cx;
    dy = j.py;
    dy = dy - j.cy;
    vx = dx * cs - dy * sn + (80'sd1 <<< 29);
    vy = dx * sn + dy * cs + (80'sd1 <<< 29);
    vx = (vx >>> 30) + j.cx;
    vy = (vy >>> 30) + j.cy;
    res.sat = 1'b0;
    if (vx > 80'sd2147483647) begin
      vx = 80'sd2147483647;
      res.sat = 1'b1;
    end else if (vx < -80'sd2147483648) begin
      vx = -80'sd2147483648;
      res.sat = 1'b1;
    end
    if (vy > 80'sd2147483647) begin
      vy = 80'sd2147483647;
      res.sat = 1'b1;
    end else if (vy < -80'sd2147483648) begin
      vy = -80'sd2147483648;
      res.sat = 1'b1;
    end
    res.rx = vx[31:0];
    res.ry = vy[31:0];
    return res;
  endfunction

  // Coordinate of a given flavor: full range, small, or an extreme value.
  function automatic logic [31:0] pick_coord(input int unsigned kind);
    logic [31:0] v;
    v = $urandom;
    case (kind)
      0: v = $urandom;
      1: v = ($urandom & 32'h001FFFFF) - 32'h00100000;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          3: v = 32'hFFFFFFFF;
          default: v = 32'h00010000;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_point(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [15:0] ang);
    point_job_t j;
    j.px  = px;
    j.py  = py;
    j.cx  = cx;
    j.cy  = cy;
    j.ang = ang;
    point_q.push_back(j);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: offers queued points in bursts and records the expected result
  // of every input transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rotated_q.push_back(rotate_about(cur_job));
        n_sent <= n_sent + 1;
      end
      if (in_valid && !in_ready) begin
        n_stall <= n_stall + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap_left > 0) begin
          tx_gap_left = tx_gap_left - 1;
          in_valid <= 1'b0;
        end else if (point_q.size() > 0) begin
          cur_job = point_q.pop_front();
          in_point_x    <= cur_job.px;
          in_point_y    <= cur_job.py;
          in_center_x   <= cur_job.cx;
          in_center_y   <= cur_job.cy;
          in_turn_angle <= cur_job.ang;
          in_valid      <= 1'b1;
          tx_burst_left = tx_burst_left - 1;
          if (tx_burst_left <= 0) begin
            tx_burst_left = $urandom_range(1, 48);
            tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches between stall patterns, with one long hold-off once
  // enough points have gone in so that the pipeline fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!rx_held && n_sent >= HOLD_AT) begin
        rx_held      = 1'b1;
        rx_hold_left = HOLD_LEN;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left = rx_hold_left - 1;
        rx_rdy = 1'b0;
      end else begin
        if (rx_mode_left <= 0) begin
          rx_mode      = rx_mode_t'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(40, 160);
        end
        rx_mode_left = rx_mode_left - 1;
        rx_beat      = rx_beat + 1;
        case (rx_mode)
          RX_OPEN:   rx_rdy = 1'b1;
          RX_COIN:   rx_rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rx_rdy = ($urandom_range(0, 3) == 0);
          default:   rx_rdy = rx_beat[2];
        endcase
      end
      out_ready <= rx_rdy;
    end
  end

  // Monitor: compares every output transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_recv <= n_recv + 1;
      if (out_saturated) begin
        n_clip <= n_clip + 1;
      end
      if (rotated_q.size() == 0) begin
        if (n_fail < MAX_REPORTS) begin
          $display("unexpected result x=%0d y=%0d sat=%0b",
                   out_rotated_x, out_rotated_y, out_saturated);
        end
        n_fail = n_fail + 1;
      end else begin
        want = rotated_q.pop_front();
        if (out_rotated_x !== want.rx || out_rotated_y !== want.ry ||
            out_saturated !== want.sat) begin
          if (n_fail < MAX_REPORTS) begin
            $display("mismatch on result %0d: expected x=%0d y=%0d sat=%0b,",
                     n_recv, want.rx, want.ry, want.sat);
            $display("  got x=%0d y=%0d sat=%0b",
                     out_rotated_x, out_rotated_y, out_saturated);
          end
          n_fail = n_fail + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned kind;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [15:0] ang;

    // Directed points: quadrant edges, the full turn and range extremes.
    add_point(32'h0, 32'h0, 32'h0, 32'h0, 16'h0000);
    add_point(32'h00030000, 32'hFFFE0000, 32'h00010000, 32'h00008000, 16'h0000);
    add_point(32'h00050000, 32'h00000000, 32'h0, 32'h0, 16'h4000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'h8000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'hC000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'hFFFF);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'h1FFF);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'h2000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'h5FFF);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'h6000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'hA000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'hE000);
    add_point(32'h00050000, 32'h00020000, 32'h0, 32'h0, 16'h0001);
    // The point on the center stays where it is.
    add_point(32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0, 16'h3A5C);
    // Extremes, most of them clipping.
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h0000);
    add_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0, 16'h8000);
    add_point(32'h80000000, 32'h80000000, 32'h0, 32'h0, 16'h8000);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h4000);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'hC000);
    add_point(32'hFFFFFFFF, 32'h00000001, 32'h00000001, 32'hFFFFFFFF, 16'h7FFF);

    // Random points, mostly well inside the range, some near it.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      ang  = 16'($urandom);
      if (kind <= 2) begin
        add_point($urandom, $urandom, $urandom, $urandom, ang);
      end else if (kind <= 6) begin
        add_point(pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1), ang);
      end else if (kind == 7) begin
        cx = $urandom;
        cy = $urandom;
        add_point(cx + pick_coord(1), cy + pick_coord(1), cx, cy, ang);
      end else if (kind == 8) begin
        add_point(pick_coord($urandom_range(0, 2)), pick_coord($urandom_range(0, 2)),
                  pick_coord($urandom_range(0, 2)), pick_coord($urandom_range(0, 2)), ang);
      end else begin
        ang = 16'($urandom_range(0, 7) * 16'h2000) + 16'($urandom_range(0, 2)) - 16'd1;
        add_point(pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1), ang);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every point sent and every result back, then a quiet stretch.
    do @(negedge clk);
    while (point_q.size() != 0 || in_valid || rotated_q.size() != 0);
    repeat (LATENCY + 8) @(posedge clk);
    @(negedge clk);
    if (rotated_q.size() != 0) begin
      $display("%0d expected results never arrived", rotated_q.size());
    end

    $display("Rotated %0d points (%0d clipped) across all quadrants and range extremes,",
             n_recv, n_clip);
    $display("with sender bursts, receiver stalls and %0d back-pressured cycles.", n_stall);
    if (n_fail == 0 && rotated_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
